// File: rtl/sbc_pkg.sv
// Shared types, constants and the sine table builder for the scan breakpoint clusterer.
`default_nettype none
package sbc_pkg;

	localparam int MAX_BEAMS_DEF        = 1024;
	localparam int TRIG_TABLE_DEPTH_DEF = 1024;
	localparam int RANGE_BITS_DEF       = 16;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [10:0] COUNT_MAX   = 11'd1024;
	localparam logic [9:0]  CLUSTER_MAX = 10'd1023;
	localparam logic [10:0] KEEP_MIN    = 11'd3;

	localparam logic [15:0] STEP_RESET   = 16'd182;
	localparam logic [15:0] THRESH_RESET = 16'd100;

	typedef enum logic {
		REG_ANGLE_STEP = 1'b0,
		REG_DIST_THRESH = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_POINT = 1'b0,
		KIND_VERDICT = 1'b1
	} rec_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PHASE,
		ST_COS,
		ST_SIN,
		ST_Y,
		ST_SQ,
		ST_DEC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic phase;
		logic cos_rd;
		logic sin_rd;
		logic y_calc;
		logic sq;
		logic decide;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic last_rec;
	} status_t;

	typedef struct packed {
		rec_kind_t          kind;
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic [9:0]         beam;
		logic [9:0]         cid;
		logic [10:0]        cnt;
		logic               keep;
		logic               mrg;
		logic               last;
	} rec_t;

	// Long division by shift and subtract, for numerators below 2^36.
	function automatic longint unsigned div_by_shift(input longint unsigned num,
			input longint unsigned den);
		longint unsigned rem;
		longint unsigned quo;
		rem = num;
		quo = 64'd0;
		for (int b = 35; b >= 0; b--) begin
			if ((rem >> b) >= den) begin
				rem = rem - (den << b);
				quo = quo | (64'd1 << b);
			end
		end
		return quo;
	endfunction

	// Quarter-wave sine in units of 2^-16 from an angle in Q30 radians.
	function automatic logic [15:0] sine_from_angle(input longint unsigned a);
		longint unsigned a2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		a2 = (a * a) >> 30;
		term = a;
		sum = a;
		for (int n = 1; n <= 10; n++) begin
			term = div_by_shift((term * a2) >> 30, longint'((2 * n) * (2 * n + 1)));
			if ((n & 1) == 1) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd65536 + (64'd1 << 29)) >> 30;
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/sbc_ctrl.sv
// Sequencer of the scan breakpoint clusterer: steps one beam through the datapath.
`default_nettype none
module sbc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sbc_pkg::cmd_t        cmd,
	input  wire sbc_pkg::status_t sts
);
	import sbc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_PHASE;
			ST_PHASE: state_d = ST_COS;
			ST_COS:   state_d = ST_SIN;
			ST_SIN:   state_d = ST_Y;
			ST_Y:     state_d = ST_SQ;
			ST_SQ:    state_d = ST_DEC;
			ST_DEC:   state_d = ST_EMIT;
			ST_EMIT:  if (out_ready && sts.last_rec) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_PHASE: cmd.phase = 1'b1;
			ST_COS:   cmd.cos_rd = 1'b1;
			ST_SIN:   cmd.sin_rd = 1'b1;
			ST_Y:     cmd.y_calc = 1'b1;
			ST_SQ:    cmd.sq = 1'b1;
			ST_DEC:   cmd.decide = 1'b1;
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.advance = out_ready;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/sbc_datapath.sv
// Datapath: trig lookup, coordinate scaling, distance tests, cluster state and result slots.
`default_nettype none
module sbc_datapath #(
	parameter int MAX_BEAMS        = sbc_pkg::MAX_BEAMS_DEF,
	parameter int TRIG_TABLE_DEPTH = sbc_pkg::TRIG_TABLE_DEPTH_DEF,
	parameter int RANGE_BITS       = sbc_pkg::RANGE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sbc_pkg::cmd_t    cmd,
	output sbc_pkg::status_t      sts,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_index,
	input  wire logic [15:0]      cfg_data,
	input  wire logic [15:0]      range_mm,
	input  wire logic             end_of_scan,
	output sbc_pkg::rec_t         rec
);
	import sbc_pkg::*;

	localparam int FULL = 4 * TRIG_TABLE_DEPTH;
	localparam int IW = $clog2(FULL);
	localparam int AW = $clog2(TRIG_TABLE_DEPTH);
	localparam int PW = RANGE_BITS + 17;
	localparam int SW = (RANGE_BITS + 2 > 18) ? RANGE_BITS + 2 : 18;
	localparam int LIM = (MAX_BEAMS < 1024 ? MAX_BEAMS : 1024) - 1;
	localparam logic [9:0] BEAM_LIMIT = 10'(LIM);
	localparam logic [AW:0] DEPTH_K = (AW + 1)'(TRIG_TABLE_DEPTH);
	localparam logic [IW-1:0] Q1 = IW'(TRIG_TABLE_DEPTH);
	localparam logic [IW-1:0] Q2 = IW'(2 * TRIG_TABLE_DEPTH);
	localparam logic [IW-1:0] Q3 = IW'(3 * TRIG_TABLE_DEPTH);
	localparam logic [IW:0] FULL_W = (IW + 1)'(FULL);

	// Constant quarter-wave table.
	logic [15:0] sine_rom [TRIG_TABLE_DEPTH];
	for (genvar k = 0; k < TRIG_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned ANG = (HALF_PI_Q30 * k) / TRIG_TABLE_DEPTH;
		localparam logic [15:0] SINE_K = sine_from_angle(ANG);
		assign sine_rom[k] = SINE_K;
	end

	logic [15:0] step_q, thr_q;
	logic [RANGE_BITS-1:0] range_q;
	logic end_q;
	logic [15:0] phase_q;
	logic [31:0] thr2_q;
	logic [15:0] rom_q;
	logic tneg_q, tfull_q;
	logic signed [16:0] x_q, y_q;
	logic [35:0] dx2_q, dy2_q, ex2_q, ey2_q;

	logic [9:0] beam_q, cc_q;
	logic [10:0] cnt_q, fcc_q;
	logic fclosed_q;
	logic signed [16:0] first_x_q, prev_x_q, prev_y_q;

	rec_t rec_q [4];
	logic [1:0] ridx_q;

	// Configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			thr_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			if (cfg_reg_t'(cfg_index) == REG_ANGLE_STEP) begin
				step_q <= cfg_data;
			end else begin
				thr_q <= cfg_data;
			end
		end
	end

	// Table address for the sine of idx, or its cosine a quarter turn on.
	logic [IW+15:0] idx_wide;
	logic [IW-1:0] idx, tidx;
	logic [IW:0] csum, cwrap;
	logic [1:0] quad;
	logic [IW-1:0] rw;
	logic [AW-1:0] r;
	logic [AW:0] kk;
	logic kfull;
	logic [AW-1:0] raddr;
	assign idx_wide = (IW + 16)'(phase_q) * (IW + 16)'(FULL);
	assign idx = idx_wide[IW+15:16];
	assign csum = {1'b0, idx} + {1'b0, Q1};
	assign cwrap = csum - FULL_W;
	assign tidx = !cmd.cos_rd ? idx : (csum >= FULL_W) ? cwrap[IW-1:0] : csum[IW-1:0];

	always_comb begin
		if (tidx >= Q3) begin
			quad = 2'd3;
			rw = tidx - Q3;
		end else if (tidx >= Q2) begin
			quad = 2'd2;
			rw = tidx - Q2;
		end else if (tidx >= Q1) begin
			quad = 2'd1;
			rw = tidx - Q1;
		end else begin
			quad = 2'd0;
			rw = tidx;
		end
	end

	assign r = rw[AW-1:0];
	assign kk = quad[0] ? DEPTH_K - {1'b0, r} : {1'b0, r};
	assign kfull = (kk == DEPTH_K);
	assign raddr = kfull ? '0 : kk[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.cos_rd || cmd.sin_rd) begin
			rom_q <= sine_rom[raddr];
			tfull_q <= kfull;
			tneg_q <= quad[1];
		end
	end

	// Coordinate from range and the looked-up trig value.
	logic [16:0] mag;
	logic [PW-1:0] prod;
	logic [SW-1:0] sv;
	logic signed [16:0] scaled;
	assign mag = tfull_q ? 17'h10000 : {1'b0, rom_q};
	assign prod = PW'(range_q) * PW'(mag);
	assign sv = SW'((prod + PW'(32768)) >> 16);
	always_comb begin
		if (tneg_q) begin
			scaled = (sv > SW'(65536)) ? -17'sd65536 : -$signed(sv[16:0]);
		end else begin
			scaled = (sv > SW'(65535)) ? 17'sd65535 : $signed(sv[16:0]);
		end
	end

	logic signed [17:0] dx, dy, ex;
	assign dx = 18'(prev_x_q) - 18'(x_q);
	assign dy = 18'(prev_y_q) - 18'(y_q);
	assign ex = 18'(first_x_q) - 18'(x_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			range_q <= RANGE_BITS'(range_mm);
			end_q <= end_of_scan;
		end
		if (cmd.phase) begin
			phase_q <= 16'(26'(beam_q) * 26'(step_q));
			thr2_q <= 32'(thr_q) * 32'(thr_q);
		end
		if (cmd.sin_rd) x_q <= scaled;
		if (cmd.y_calc) y_q <= scaled;
		if (cmd.sq) begin
			dx2_q <= 36'(dx) * 36'(dx);
			dy2_q <= 36'(dy) * 36'(dy);
			ex2_q <= 36'(ex) * 36'(ex);
			ey2_q <= 36'(y_q) * 36'(y_q);
		end
	end

	// Cluster decision and result slots.
	logic near, close_first;
	assign near = ({1'b0, dx2_q} + {1'b0, dy2_q}) <= 37'(thr2_q);
	assign close_first = ({1'b0, ex2_q} + {1'b0, ey2_q}) <= 37'(thr2_q);

	logic [9:0] cc_d;
	logic [10:0] cnt_d, fcc_d;
	logic fclosed_d;
	logic [11:0] total;
	logic [10:0] total_sat;
	rec_t slot [4];
	logic [2:0] n;

	function automatic rec_t verdict(input logic [9:0] cid, input logic [10:0] cnt,
			input logic mrg);
		rec_t v;
		v = '0;
		v.kind = KIND_VERDICT;
		v.cid = cid;
		v.cnt = cnt;
		v.mrg = mrg;
		v.keep = !mrg && (cnt > KEEP_MIN);
		return v;
	endfunction

	always_comb begin
		cc_d = cc_q;
		cnt_d = cnt_q;
		fcc_d = fcc_q;
		fclosed_d = fclosed_q;
		for (int i = 0; i < 4; i++) slot[i] = '0;
		n = 3'd0;
		if (beam_q == 10'd0) begin
			cc_d = 10'd0;
			cnt_d = 11'd1;
			fcc_d = 11'd0;
			fclosed_d = 1'b0;
		end else if (near) begin
			cnt_d = (cnt_q < COUNT_MAX) ? cnt_q + 11'd1 : COUNT_MAX;
		end else begin
			if (cc_q == 10'd0 && !fclosed_q) begin
				fcc_d = cnt_q;
				fclosed_d = 1'b1;
			end else begin
				slot[n[1:0]] = verdict(cc_q, cnt_q, 1'b0);
				n = n + 3'd1;
			end
			cc_d = (cc_q < CLUSTER_MAX) ? cc_q + 10'd1 : CLUSTER_MAX;
			cnt_d = 11'd1;
		end
		slot[n[1:0]] = '0;
		slot[n[1:0]].kind = KIND_POINT;
		slot[n[1:0]].x = x_q;
		slot[n[1:0]].y = y_q;
		slot[n[1:0]].beam = beam_q;
		slot[n[1:0]].cid = cc_d;
		n = n + 3'd1;
		total = 12'(fcc_d) + 12'(cnt_d);
		total_sat = (total > 12'(COUNT_MAX)) ? COUNT_MAX : total[10:0];
		if (end_q) begin
			if (!fclosed_d) begin
				slot[n[1:0]] = verdict(10'd0, cnt_d, 1'b0);
				n = n + 3'd1;
			end else if (close_first) begin
				slot[n[1:0]] = verdict(cc_d, cnt_d, 1'b1);
				slot[n[1:0] + 2'd1] = verdict(10'd0, total_sat, 1'b0);
				n = n + 3'd2;
			end else begin
				slot[n[1:0]] = verdict(cc_d, cnt_d, 1'b0);
				slot[n[1:0] + 2'd1] = verdict(10'd0, fcc_d, 1'b0);
				n = n + 3'd2;
			end
		end
		slot[2'(n - 3'd1)].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q <= '0;
			cc_q <= '0;
			cnt_q <= '0;
			fcc_q <= '0;
			fclosed_q <= 1'b0;
			first_x_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			ridx_q <= '0;
		end else if (cmd.decide) begin
			ridx_q <= '0;
			if (end_q) begin
				beam_q <= '0;
				cc_q <= '0;
				cnt_q <= '0;
				fcc_q <= '0;
				fclosed_q <= 1'b0;
				first_x_q <= '0;
				prev_x_q <= '0;
				prev_y_q <= '0;
			end else begin
				beam_q <= (beam_q < BEAM_LIMIT) ? beam_q + 10'd1 : BEAM_LIMIT;
				cc_q <= cc_d;
				cnt_q <= cnt_d;
				fcc_q <= fcc_d;
				fclosed_q <= fclosed_d;
				if (beam_q == 10'd0) first_x_q <= x_q;
				prev_x_q <= x_q;
				prev_y_q <= y_q;
			end
		end else if (cmd.advance) begin
			ridx_q <= ridx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			for (int i = 0; i < 4; i++) rec_q[i] <= slot[i];
		end
	end

	assign rec = rec_q[ridx_q];
	assign sts.last_rec = rec_q[ridx_q].last;

endmodule
`default_nettype wire

// File: rtl/scan_breakpoint_clusterer.sv
// Top level of the scan breakpoint clusterer.
//
// Range samples of one lidar scan enter in beam order on the in channel
// (range_mm, end_of_scan). Each request yields one point record, preceded by
// the verdict of a cluster it closes and, on the final beam, followed by the
// verdicts of the last cluster and of cluster zero: one to four results,
// with last set on the final one. Results leave on the out channel.
// The cfg channel writes angle_step (index 0) and distance_threshold
// (index 1); it is always ready and should be used only while idle.
// After acceptance a beam passes through the phase multiply, two reads of
// the single sine table port, scaling and the distance squares before its
// first result; then results leave one per cycle while out_ready is high.
// One beam is in work at a time.
// A stalled receiver holds the current result steady and no new beam is
// taken until the last result is gone. Reset clears the scan state and
// loads the register defaults; the sine table is constant and needs no fill.
`default_nettype none
module scan_breakpoint_clusterer #(
	parameter int MAX_BEAMS        = sbc_pkg::MAX_BEAMS_DEF,
	parameter int TRIG_TABLE_DEPTH = sbc_pkg::TRIG_TABLE_DEPTH_DEF,
	parameter int RANGE_BITS       = sbc_pkg::RANGE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        range_mm,
	input  wire logic               end_of_scan,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    record_kind,
	output logic signed [16:0]      x_mm,
	output logic signed [16:0]      y_mm,
	output logic [9:0]              beam_index,
	output logic [9:0]              cluster_id,
	output logic [10:0]             point_count,
	output logic                    keep,
	output logic                    merged_into_first,
	output logic                    last
);
	import sbc_pkg::*;

	cmd_t cmd;
	status_t sts;
	rec_t rec;

	assign cfg_ready = 1'b1;

	sbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sbc_datapath #(
		.MAX_BEAMS        (MAX_BEAMS),
		.TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH),
		.RANGE_BITS       (RANGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.range_mm    (range_mm),
		.end_of_scan (end_of_scan),
		.rec         (rec)
	);

	assign record_kind = rec.kind;
	assign x_mm = rec.x;
	assign y_mm = rec.y;
	assign beam_index = rec.beam;
	assign cluster_id = rec.cid;
	assign point_count = rec.cnt;
	assign keep = rec.keep;
	assign merged_into_first = rec.mrg;
	assign last = rec.last;

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the scan breakpoint clusterer.
`timescale 1ns / 100ps
`default_nettype none
import sbc_pkg::*;

class cluster_scoreboard;
	rec_t        pending_q[$];
	int          errors;
	logic [15:0] step;
	logic [15:0] thresh;
	logic [9:0]  beam;
	logic [9:0]  cur_id;
	logic [10:0] cur_cnt;
	logic [10:0] first_cnt;
	bit          first_closed;
	longint      first_x;
	longint      prev_x;
	longint      prev_y;
	longint      sine_q[1024];

	function new();
		longint unsigned a, a2, term, sum, v;
		step = STEP_RESET;
		thresh = THRESH_RESET;
		errors = 0;
		clear_scan();
		// Quarter-wave table from a Taylor series in Q30 radians.
		for (int k = 0; k < 1024; k++) begin
			a = (HALF_PI_Q30 * longint'(k)) / 1024;
			a2 = (a * a) >> 30;
			term = a;
			sum = a;
			for (int n = 1; n <= 10; n++) begin
				term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = (sum > term) ? sum - term : 0;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum * 65536 + (64'd1 << 29)) >> 30;
			sine_q[k] = (v > 65535) ? 65535 : longint'(v);
		end
	endfunction

	function void clear_scan();
		beam = 0;
		cur_id = 0;
		cur_cnt = 0;
		first_cnt = 0;
		first_closed = 0;
		first_x = 0;
		prev_x = 0;
		prev_y = 0;
	endfunction

	function void set_reg(cfg_reg_t idx, logic [15:0] val);
		if (idx == REG_ANGLE_STEP) begin
			step = val;
		end else begin
			thresh = val;
		end
	endfunction

	function longint quarter(int k);
		return (k >= 1024) ? 65536 : sine_q[k];
	endfunction

	function longint wave(int idx);
		int     q;
		int     r;
		longint m;
		q = (idx / 1024) & 3;
		r = idx % 1024;
		m = (q & 1) ? quarter(1024 - r) : quarter(r);
		return (q >= 2) ? -m : m;
	endfunction

	function longint coord(longint rng, longint t);
		longint mag;
		longint v;
		mag = (t < 0) ? -t : t;
		v = (rng * mag + 32768) >>> 16;
		if (t < 0) v = -v;
		if (v > 65535) v = 65535;
		if (v < -65536) v = -65536;
		return v;
	endfunction

	function longint gap2(longint ax, longint ay, longint bx, longint by);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
	endfunction

	function void push_rec(rec_kind_t kind, longint x, longint y, logic [9:0] b,
			logic [9:0] cid, logic [10:0] cnt, bit mrg);
		rec_t r;
		r.kind = kind;
		r.x = x[16:0];
		r.y = y[16:0];
		r.beam = b;
		r.cid = cid;
		r.cnt = cnt;
		r.keep = (kind == KIND_VERDICT) && !mrg && (cnt > KEEP_MIN);
		r.mrg = mrg;
		r.last = 0;
		pending_q = {pending_q, r};
	endfunction

	function void note_beam(logic [15:0] rng, bit eos);
		int     phase;
		int     idx;
		longint x;
		longint y;
		longint thr2;
		int     total;
		phase = (int'(beam) * int'(step)) & 16'hFFFF;
		idx = phase >> 4;
		x = coord(rng, wave((idx + 1024) % 4096));
		y = coord(rng, wave(idx));
		thr2 = longint'(thresh) * longint'(thresh);
		if (beam == 0) begin
			cur_id = 0;
			cur_cnt = 1;
			first_cnt = 0;
			first_closed = 0;
			first_x = x;
		end else if (gap2(prev_x, prev_y, x, y) <= thr2) begin
			if (cur_cnt < COUNT_MAX) cur_cnt++;
		end else begin
			// Cluster zero is held back until the end of the scan.
			if (cur_id == 0 && !first_closed) begin
				first_cnt = cur_cnt;
				first_closed = 1;
			end else begin
				push_rec(KIND_VERDICT, 0, 0, 0, cur_id, cur_cnt, 0);
			end
			if (cur_id < CLUSTER_MAX) cur_id++;
			cur_cnt = 1;
		end
		push_rec(KIND_POINT, x, y, beam, cur_id, 0, 0);
		prev_x = x;
		prev_y = y;
		if (eos) begin
			if (!first_closed) begin
				push_rec(KIND_VERDICT, 0, 0, 0, 0, cur_cnt, 0);
			end else if (gap2(first_x, 0, x, y) <= thr2) begin
				total = int'(first_cnt) + int'(cur_cnt);
				if (total > COUNT_MAX) total = COUNT_MAX;
				push_rec(KIND_VERDICT, 0, 0, 0, cur_id, cur_cnt, 1);
				push_rec(KIND_VERDICT, 0, 0, 0, 0, total[10:0], 0);
			end else begin
				push_rec(KIND_VERDICT, 0, 0, 0, cur_id, cur_cnt, 0);
				push_rec(KIND_VERDICT, 0, 0, 0, 0, first_cnt, 0);
			end
			clear_scan();
		end else if (beam < 10'd1023) begin
			beam++;
		end
		pending_q[pending_q.size() - 1].last = 1;
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_record(rec_t got);
		rec_t want;
		if (pending_q.size() == 0) begin
			report("record with nothing pending, kind", got.kind, -1);
			return;
		end
		want = pending_q.pop_front();
		if (got.kind != want.kind) report("record_kind", got.kind, want.kind);
		if (got.x != want.x) report("x_mm", got.x, want.x);
		if (got.y != want.y) report("y_mm", got.y, want.y);
		if (got.beam != want.beam) report("beam_index", got.beam, want.beam);
		if (got.cid != want.cid) report("cluster_id", got.cid, want.cid);
		if (got.cnt != want.cnt) report("point_count", got.cnt, want.cnt);
		if (got.keep != want.keep) report("keep", got.keep, want.keep);
		if (got.mrg != want.mrg) report("merged_into_first", got.mrg, want.mrg);
		if (got.last != want.last) report("last", got.last, want.last);
	endtask
endclass

module testbench;
	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	cfg_reg_t           cfg_index = REG_ANGLE_STEP;
	logic [15:0]        cfg_data = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [15:0]        range_mm = 0;
	logic               end_of_scan = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic               record_kind;
	logic signed [16:0] x_mm;
	logic signed [16:0] y_mm;
	logic [9:0]         beam_index;
	logic [9:0]         cluster_id;
	logic [10:0]        point_count;
	logic               keep;
	logic               merged_into_first;
	logic               last;

	cluster_scoreboard sb = new();
	int  cycles = 0;
	bit  calm = 0;
	bit  hold_req = 0;
	int  beams_sent = 0;

	scan_breakpoint_clusterer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .range_mm(range_mm),
		.end_of_scan(end_of_scan),
		.out_valid(out_valid), .out_ready(out_ready), .record_kind(record_kind),
		.x_mm(x_mm), .y_mm(y_mm), .beam_index(beam_index), .cluster_id(cluster_id),
		.point_count(point_count), .keep(keep), .merged_into_first(merged_into_first),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1000000) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		rec_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind = rec_kind_t'(record_kind);
			got.x = x_mm;
			got.y = y_mm;
			got.beam = beam_index;
			got.cid = cluster_id;
			got.cnt = point_count;
			got.keep = keep;
			got.mrg = merged_into_first;
			got.last = last;
			sb.check_record(got);
		end
	end

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Returns at the edge where the request is taken; the caller drives next.
	task send_beam(input logic [15:0] rng, input bit eos);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1;
		range_mm <= rng;
		end_of_scan <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_beam(rng, eos);
		beams_sent++;
	endtask

	task settle();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Mostly smooth surfaces with occasional jumps and random scan lengths.
	task random_scan(input int len);
		int rng;
		rng = $urandom_range(0, 65535);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				rng = $urandom_range(0, 65535);
			end else begin
				rng = rng + $urandom_range(0, 200) - 100;
				if (rng < 0) rng = 0;
				if (rng > 65535) rng = 65535;
			end
			send_beam(rng[15:0], i == len - 1);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: one-beam scans at both range extremes, then three clusters.
		send_beam(16'hFFFF, 1);
		send_beam(16'h0000, 1);
		for (int i = 0; i < 5; i++) send_beam(1000, 0);
		for (int i = 0; i < 5; i++) send_beam(5000, 0);
		send_beam(1000, 1);
		settle();

		// Final cluster merged back into cluster zero.
		write_reg(REG_ANGLE_STEP, 16'd0);
		for (int i = 0; i < 3; i++) send_beam(500, 0);
		send_beam(5000, 0);
		send_beam(5000, 0);
		send_beam(520, 1);
		settle();

		beams_sent = 0;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_reg(REG_ANGLE_STEP, STEP_RESET);
					write_reg(REG_DIST_THRESH, THRESH_RESET);
				end
				1: begin
					write_reg(REG_ANGLE_STEP, 16'hFFFF);
					write_reg(REG_DIST_THRESH, 16'hFFFF);
				end
				default: begin
					write_reg(REG_ANGLE_STEP, $urandom_range(0, 4096));
					write_reg(REG_DIST_THRESH, $urandom_range(0, 600));
				end
			endcase
			if (p == 2) hold_req = 1;
			if (p == 5) calm = 1;
			while (beams_sent < (p + 1) * 42) random_scan($urandom_range(1, 20));
			settle();
		end

		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
